// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, register indexes and saturation helpers for the scalar
// Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int SKF_DW  = 32;   // Q16.16 data word
    localparam int SKF_UW  = 31;   // non-negative register word
    localparam int SKF_IW  = 3;    // configuration index width

    // Configuration register indexes
    localparam logic [SKF_IW-1:0] REG_A  = 3'd0;
    localparam logic [SKF_IW-1:0] REG_C  = 3'd1;
    localparam logic [SKF_IW-1:0] REG_R  = 3'd2;
    localparam logic [SKF_IW-1:0] REG_Q  = 3'd3;
    localparam logic [SKF_IW-1:0] REG_X0 = 3'd4;
    localparam logic [SKF_IW-1:0] REG_P0 = 3'd5;

    // Q16.16 one and saturation limits
    localparam logic signed [SKF_DW-1:0] Q_ONE   = 32'sd65536;
    localparam logic signed [SKF_DW-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SKF_DW-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [SKF_DW-1:0] t_q;
    typedef logic        [SKF_UW-1:0] t_uq;

    // Saturate a 48-bit product (already shifted by 16) to 32 bits
    function automatic t_q f_sat48(input logic signed [47:0] v);
        t_q res;
        if (v > 48'sh0000_7FFF_FFFF) begin
            res = SAT_MAX;
        end else if (v < -48'sh0000_8000_0000) begin
            res = SAT_MIN;
        end else begin
            res = v[SKF_DW-1:0];
        end
        return res;
    endfunction

    // Saturate a 33-bit sum to 32 bits
    function automatic t_q f_sat33(input logic signed [SKF_DW:0] v);
        t_q res;
        if (v[SKF_DW] != v[SKF_DW-1]) begin
            res = v[SKF_DW] ? SAT_MIN : SAT_MAX;
        end else begin
            res = v[SKF_DW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/skf_meas_if.sv =====
// ----------------------------------------------------------------------------
// skf_meas_if
// Measurement channel: valid/ready handshake with one Q16.16 sample and a
// block-end flag.
// ----------------------------------------------------------------------------
interface skf_meas_if;
    import skf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SKF_DW-1:0] measurement;
    logic                     last_sample;

    modport source (output valid, output measurement, output last_sample, input ready);
    modport sink   (input valid, input measurement, input last_sample, output ready);

endinterface

// ===== rtl/skf_est_if.sv =====
// ----------------------------------------------------------------------------
// skf_est_if
// Estimate channel: valid/ready handshake with one filtered Q16.16 value and
// the block-end flag of its sample.
// ----------------------------------------------------------------------------
interface skf_est_if;
    import skf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SKF_DW-1:0] filtered_value;
    logic                     last_out;

    modport source (output valid, output filtered_value, output last_out, input ready);
    modport sink   (input valid, input filtered_value, input last_out, output ready);

endinterface

// ===== rtl/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter on signed Q16.16 samples, built around one
// shared 32x32 multiplier and an iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_meas    in   valid/ready        measurement[31:0], last_sample
//  o_est     out  valid/ready        filtered_value[31:0], last_out
//  i_cfg_*   in   write enable only  i_cfg_idx[2:0], i_cfg_data[31:0]
//
//  An item runs ten products on the shared multiplier, each in a multiply and
//  a write-back state, and waits on the radix-4 gain divider after the
//  numerator product (skipped when the innovation covariance is not positive,
//  cut short when the gain saturates at once); the done state then loads the
//  output register. i_meas.ready is high only while the sequencer is idle, so
//  a new sample is taken only once the previous one has left the done state.
//  One finished estimate may wait in the output register while the next
//  sample runs; a second one holds the sequencer in its done state.
//  Reset is synchronous, active low, and leaves a state reload pending.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    skf_meas_if.sink                         i_meas,
    skf_est_if.source                        o_est,
    input  logic                             i_cfg_we,
    input  logic        [skf_pkg::SKF_IW-1:0] i_cfg_idx,
    input  logic        [skf_pkg::SKF_DW-1:0] i_cfg_data
);
    import skf_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_WB   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // Multiplier operations, in issue order
    localparam logic [3:0] OP_XP  = 4'd0;  // A*x
    localparam logic [3:0] OP_AP  = 4'd1;  // A*P
    localparam logic [3:0] OP_APA = 4'd2;  // (A*P)*A + Q
    localparam logic [3:0] OP_CX  = 4'd3;  // z - C*xp
    localparam logic [3:0] OP_CP  = 4'd4;  // C*pp
    localparam logic [3:0] OP_CPC = 4'd5;  // (C*pp)*C + R
    localparam logic [3:0] OP_NUM = 4'd6;  // pp*C, feeds the divider
    localparam logic [3:0] OP_KY  = 4'd7;  // xp + K*y
    localparam logic [3:0] OP_KC  = 4'd8;  // 1 - K*C
    localparam logic [3:0] OP_PN  = 4'd9;  // (1 - K*C)*pp

    // Configuration registers
    t_q  r_a, r_c, r_x0;
    t_uq r_r, r_q, r_p0;

    // Filter state and intermediates
    t_q  r_x;
    t_uq r_p;
    logic r_start;
    t_q  r_z;
    logic r_last;
    t_q  r_xp, r_pp, r_y, r_s, r_k, r_t;
    logic signed [2*SKF_DW-1:0] r_prod;

    // Sequencer
    logic [2:0] r_state, n_state;
    logic [3:0] r_op;

    // Output register
    logic r_ov_valid;
    t_q   r_ov_value;
    logic r_ov_last;

    t_q   w_opa, w_opb;
    t_q   w_m;
    logic w_s_pos;
    logic w_accept;
    logic w_out_free;
    logic w_div_start;
    logic w_div_done;
    t_q   w_div_quo;

    assign w_accept   = i_meas.valid && i_meas.ready;
    assign w_out_free = !r_ov_valid || o_est.ready;
    assign w_s_pos    = !r_s[SKF_DW-1] && (r_s != '0);
    assign w_m        = f_sat48(r_prod[2*SKF_DW-1:16]);

    // Select operands for the shared multiplier
    always_comb begin
        case (r_op)
            OP_XP:   begin w_opa = r_a;  w_opb = r_x;          end
            OP_AP:   begin w_opa = r_a;  w_opb = {1'b0, r_p};  end
            OP_APA:  begin w_opa = r_t;  w_opb = r_a;          end
            OP_CX:   begin w_opa = r_c;  w_opb = r_xp;         end
            OP_CP:   begin w_opa = r_c;  w_opb = r_pp;         end
            OP_CPC:  begin w_opa = r_t;  w_opb = r_c;          end
            OP_NUM:  begin w_opa = r_pp; w_opb = r_c;          end
            OP_KY:   begin w_opa = r_k;  w_opb = r_y;          end
            OP_KC:   begin w_opa = r_k;  w_opb = r_c;          end
            OP_PN:   begin w_opa = r_t;  w_opb = r_pp;         end
            default: begin w_opa = '0;   w_opb = '0;           end
        endcase
    end

    // Next sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                if (r_op == OP_NUM) begin
                    n_state = w_s_pos ? ST_DIV : ST_MUL;
                end else if (r_op == OP_PN) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV: begin
                if (w_div_done) n_state = ST_MUL;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Start the gain division after the numerator product is ready
    assign w_div_start = (r_state == ST_WB) && (r_op == OP_NUM) && w_s_pos;

    skf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_m),
        .i_den   (r_s[SKF_UW-1:0]),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Configuration writes; out-of-range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a  <= Q_ONE;
            r_c  <= Q_ONE;
            r_r  <= 31'd26214;
            r_q  <= 31'd655;
            r_x0 <= '0;
            r_p0 <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_A:   r_a  <= i_cfg_data;
                REG_C:   r_c  <= i_cfg_data;
                REG_R:   r_r  <= i_cfg_data[SKF_UW-1:0];
                REG_Q:   r_q  <= i_cfg_data[SKF_UW-1:0];
                REG_X0:  r_x0 <= i_cfg_data;
                REG_P0:  r_p0 <= i_cfg_data[SKF_UW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_XP;
            r_start    <= 1'b1;
            r_ov_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load the output register when the item finishes, drop it once taken
            if (r_state == ST_DONE && w_out_free) begin
                r_ov_valid <= 1'b1;
            end else if (o_est.ready) begin
                r_ov_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op    <= OP_XP;
                        r_start <= i_meas.last_sample;
                    end
                end
                ST_WB: begin
                    r_op <= r_op + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // Datapath: reload, product register and write-back
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_z    <= i_meas.measurement;
            r_last <= i_meas.last_sample;
            if (r_start) begin
                r_x <= r_x0;
                r_p <= r_p0;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_opa * w_opb;
        end
        if (r_state == ST_WB) begin
            case (r_op)
                OP_XP:  r_xp <= w_m;
                OP_AP:  r_t  <= w_m;
                OP_APA: r_pp <= f_sat33({w_m[SKF_DW-1], w_m} + {2'b00, r_q});
                OP_CX:  r_y  <= f_sat33({r_z[SKF_DW-1], r_z} - {w_m[SKF_DW-1], w_m});
                OP_CP:  r_t  <= w_m;
                OP_CPC: r_s  <= f_sat33({w_m[SKF_DW-1], w_m} + {2'b00, r_r});
                OP_NUM: begin
                    // non-positive innovation covariance gives zero gain
                    if (!w_s_pos) r_k <= '0;
                end
                OP_KY:  r_x  <= f_sat33({r_xp[SKF_DW-1], r_xp} + {w_m[SKF_DW-1], w_m});
                OP_KC:  r_t  <= f_sat33({Q_ONE[SKF_DW-1], Q_ONE} - {w_m[SKF_DW-1], w_m});
                OP_PN:  r_p  <= w_m[SKF_DW-1] ? '0 : w_m[SKF_UW-1:0];
                default: ;
            endcase
        end
        if (w_div_done) begin
            r_k <= w_div_quo;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_ov_value <= r_x;
            r_ov_last  <= r_last;
        end
    end

    assign i_meas.ready         = (r_state == ST_IDLE);
    assign o_est.valid          = r_ov_valid;
    assign o_est.filtered_value = r_ov_value;
    assign o_est.last_out       = r_ov_last;

    a_out_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov_valid) |-> $past(r_state == ST_DONE))
        else $error("output loaded outside the done state");

    a_div_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished while sequencer not waiting");

    a_pn_to_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WB && r_op == OP_PN) |=> (r_state == ST_DONE))
        else $error("covariance update did not finish the item");

endmodule

// ===== rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div
// Iterative radix-4 divider for the Kalman gain: (num * 2^16) / den,
// truncated toward zero and saturated to signed 32 bits. den must be > 0.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [skf_pkg::SKF_DW-1:0] i_num,
    input  logic        [skf_pkg::SKF_UW-1:0] i_den,
    output logic                             o_done,
    output logic signed [skf_pkg::SKF_DW-1:0] o_quo
);
    import skf_pkg::*;

    logic              r_busy;
    logic [3:0]        r_cnt;
    logic              r_neg;
    logic [SKF_UW-1:0] r_den;
    logic [SKF_UW-1:0] r_rem;
    logic [SKF_DW-1:0] r_dvd;
    logic              r_done;
    t_q                r_quo;

    logic [SKF_DW-1:0] w_mag;
    logic              w_ovf;
    logic [SKF_DW-1:0] w_t1;
    logic [SKF_DW-1:0] w_t2;
    logic              w_ge1;
    logic              w_ge2;
    logic [SKF_UW-1:0] w_r1;
    logic [SKF_UW-1:0] w_r2;
    logic [SKF_DW-1:0] n_dvd;

    // Magnitude of the numerator and early overflow check
    assign w_mag = i_num[SKF_DW-1] ? (~i_num + 32'd1) : i_num;
    assign w_ovf = {14'd0, w_mag[SKF_DW-1:15]} >= i_den;

    // Two restoring steps per cycle; quotient bits shift in behind the dividend
    always_comb begin
        w_t1  = {r_rem, r_dvd[SKF_DW-1]};
        w_ge1 = w_t1 >= {1'b0, r_den};
        w_r1  = w_ge1 ? 31'(w_t1 - {1'b0, r_den}) : w_t1[SKF_UW-1:0];
        w_t2  = {w_r1, r_dvd[SKF_DW-2]};
        w_ge2 = w_t2 >= {1'b0, r_den};
        w_r2  = w_ge2 ? 31'(w_t2 - {1'b0, r_den}) : w_t2[SKF_UW-1:0];
        n_dvd = {r_dvd[SKF_DW-3:0], w_ge1, w_ge2};
    end

    // Control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_neg <= i_num[SKF_DW-1];
                r_den <= i_den;
                r_cnt <= '0;
                if (w_ovf) begin
                    // quotient cannot fit: saturate at once
                    r_done <= 1'b1;
                    r_quo  <= i_num[SKF_DW-1] ? SAT_MIN : SAT_MAX;
                end else begin
                    r_busy <= 1'b1;
                    r_rem  <= {15'd0, w_mag[SKF_DW-1:16]};
                    r_dvd  <= {w_mag[15:0], 16'd0};
                end
            end else if (r_busy) begin
                r_rem <= w_r2;
                r_dvd <= n_dvd;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= r_neg ? t_q'(~n_dvd + 32'd1) : t_q'(n_dvd);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");

    a_done_pulse : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held longer than one cycle");

    a_last_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 4'd15 && !i_start) |=> r_done)
        else $error("divider missed completion");

endmodule
